// File: rtl/core/nvmp_pkg.sv
package nvmp_pkg;

    localparam int CAPACITY  = 1024;
    localparam int VAL_W     = 31;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int COUNT_W   = 11;
    localparam int TOT_W     = 20;
    localparam int ALU_W     = 32;

    localparam int TOTAL_MOD = 1000000;
    // Restoring reduction: enough steps to bring any total-plus-distance below the modulus.
    localparam int MOD_STEPS = 12;
    localparam int MODC_W    = $clog2(MOD_STEPS);
    localparam logic [ALU_W-1:0] MOD_TOP = ALU_W'(TOTAL_MOD * (2 ** (MOD_STEPS - 1)));

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             ge;
        logic             eq;
    } alu_rsp_t;

endpackage

// File: rtl/core/nvmp_if.sv
interface nvmp_in_if;
    logic                      valid;
    logic                      ready;
    logic                      item_kind;
    logic [nvmp_pkg::VAL_W-1:0] item_value;

    modport source (output valid, output item_kind, output item_value, input ready);
    modport sink   (input valid, input item_kind, input item_value, output ready);
endinterface

interface nvmp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        matched;
    logic [nvmp_pkg::VAL_W-1:0]   matched_value;
    logic [nvmp_pkg::VAL_W-1:0]   distance;
    logic [nvmp_pkg::TOT_W-1:0]   running_total;
    logic [nvmp_pkg::COUNT_W-1:0] pool_count;
    logic                        overflow;

    modport source (output valid, output matched, output matched_value, output distance,
                    output running_total, output pool_count, output overflow, input ready);
    modport sink   (input valid, input matched, input matched_value, input distance,
                    input running_total, input pool_count, input overflow, output ready);
endinterface

// File: rtl/core/nvmp_alu.sv
module nvmp_alu
    import nvmp_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0]   sum;
    logic [ALU_W-1:0] opb;

    // One adder serves both add and subtract; the carry out of a - b is a >= b.
    assign opb = req.sub ? ~req.b : req.b;
    assign sum = {1'b0, req.a} + {1'b0, opb} + {{ALU_W{1'b0}}, req.sub};

    assign rsp.res = sum[ALU_W-1:0];
    assign rsp.ge  = sum[ALU_W];
    assign rsp.eq  = (req.a == req.b);

endmodule

// File: rtl/core/nearest_value_match_pool.sv
// Channel   Port     Role    Payload
// input     items    sink    item_kind, item_value
// output    results  source  matched, matched_value, distance, running_total,
//                            pool_count, overflow
//
// Each item is accepted, then a binary search runs over the one read port of the sorted
// store. An insert shifts the entries above its slot up by one and writes the value; a match
// fetches and compares the two neighbors, adds the distance to the total, reduces it modulo
// TOTAL_MOD and shifts the entries above the removed one down. A full pool reports overflow.
// Reset is asynchronous and active low; it empties the pool at once, no clearing pass.
// The input is not ready while an item is in progress. A finished result waits in the
// output register while the next item is taken; a second one holds the block until it drains.

module nearest_value_match_pool
    import nvmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    nvmp_in_if.sink          items,
    nvmp_out_if.source       results
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SRCH   = 14'b00000000000010,
        S_SRCH_W = 14'b00000000000100,
        S_SHUP   = 14'b00000000001000,
        S_PUT    = 14'b00000000010000,
        S_NB0    = 14'b00000000100000,
        S_NB1    = 14'b00000001000000,
        S_NB2    = 14'b00000010000000,
        S_DLO    = 14'b00000100000000,
        S_PICK   = 14'b00001000000000,
        S_ADD    = 14'b00010000000000,
        S_MOD    = 14'b00100000000000,
        S_SHDN   = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  size_reg, size_next;
    logic              kind_reg, kind_next;
    logic [TOT_W-1:0]  total_reg, total_next;

    logic              ikind_reg, ikind_next;
    logic [VAL_W-1:0]  ival_reg, ival_next;
    logic              strict_reg, strict_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  wa_reg, wa_next;
    logic [VAL_W-1:0]  hval_reg, hval_next;
    logic [VAL_W-1:0]  lval_reg, lval_next;
    logic [VAL_W-1:0]  dhi_reg, dhi_next;
    logic [VAL_W-1:0]  dlo_reg, dlo_next;
    logic              match_reg, match_next;
    logic              ovf_reg, ovf_next;
    logic [VAL_W-1:0]  mval_reg, mval_next;
    logic [VAL_W-1:0]  dist_reg, dist_next;
    logic [ALU_W-1:0]  acc_reg, acc_next;
    logic [ALU_W-1:0]  modsh_reg, modsh_next;
    logic [MODC_W-1:0] mcnt_reg, mcnt_next;

    logic              ovalid_reg, ovalid_next;
    logic              omatch_reg, omatch_next;
    logic [VAL_W-1:0]  omval_reg, omval_next;
    logic [VAL_W-1:0]  odist_reg, odist_next;
    logic [TOT_W-1:0]  otot_reg, otot_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              oovf_reg, oovf_next;

    logic [VAL_W-1:0]  mem [CAPACITY];
    logic [VAL_W-1:0]  rdata_reg;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [VAL_W-1:0]  wdata;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic [CNT_W:0]    mid_sum;
    logic              accept;
    logic              is_insert;
    logic              issue;
    logic              have_hi;
    logic              have_lo;
    logic              pick_hi;
    logic [CNT_W-1:0]  pick;
    logic [31:0]       ocnt_ext;

    nvmp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign accept    = items.valid && items.ready;
    assign is_insert = (size_reg == '0) || (kind_reg == items.item_kind);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign have_hi   = (lo_reg < size_reg);
    assign have_lo   = (lo_reg != '0);

    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        kind_next   = kind_reg;
        total_next  = total_reg;
        ikind_next  = ikind_reg;
        ival_next   = ival_reg;
        strict_next = strict_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        wa_next     = wa_reg;
        hval_next   = hval_reg;
        lval_next   = lval_reg;
        dhi_next    = dhi_reg;
        dlo_next    = dlo_reg;
        match_next  = match_reg;
        ovf_next    = ovf_reg;
        mval_next   = mval_reg;
        dist_next   = dist_reg;
        acc_next    = acc_reg;
        modsh_next  = modsh_reg;
        mcnt_next   = mcnt_reg;
        ovalid_next = ovalid_reg;
        omatch_next = omatch_reg;
        omval_next  = omval_reg;
        odist_next  = odist_reg;
        otot_next   = otot_reg;
        ocnt_next   = ocnt_reg;
        oovf_next   = oovf_reg;

        raddr   = mid_reg[IDX_W-1:0];
        we      = 1'b0;
        waddr   = wa_reg;
        wdata   = rdata_reg;
        alu_req = '{sub: 1'b1, a: {1'b0, rdata_reg}, b: {1'b0, ival_reg}};
        issue   = 1'b0;
        pick_hi = 1'b0;
        pick    = lo_reg;

        if (results.valid && results.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ikind_next  = items.item_kind;
                    ival_next   = items.item_value;
                    strict_next = is_insert;
                    match_next  = !is_insert;
                    mval_next   = '0;
                    dist_next   = '0;
                    lo_next     = '0;
                    hi_next     = size_reg;
                    if (is_insert && (size_reg >= CNT_W'(CAPACITY)))
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ovf_next   = 1'b0;
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                mid_next = mid_sum[CNT_W:1];
                raddr    = mid_sum[IDX_W:1];
                if (lo_reg < hi_reg)
                begin
                    state_next = S_SRCH_W;
                end
                else if (strict_reg)
                begin
                    ptr_next   = size_reg;
                    pend_next  = 1'b0;
                    state_next = S_SHUP;
                end
                else
                begin
                    state_next = S_NB0;
                end
            end
            S_SRCH_W:
            begin
                alu_req = '{sub: 1'b1, a: {1'b0, rdata_reg}, b: {1'b0, ival_reg}};
                if (!alu_rsp.ge || (strict_reg && alu_rsp.eq))
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_SHUP:
            begin
                // Read one entry below while the previous read lands one slot higher.
                issue     = (ptr_reg > lo_reg);
                raddr     = IDX_W'(ptr_reg - CNT_W'(1));
                we        = pend_reg;
                pend_next = issue;
                wa_next   = ptr_reg[IDX_W-1:0];
                if (issue)
                begin
                    ptr_next = ptr_reg - CNT_W'(1);
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = lo_reg[IDX_W-1:0];
                wdata      = ival_reg;
                size_next  = size_reg + CNT_W'(1);
                kind_next  = ikind_reg;
                state_next = S_FIN;
            end
            S_NB0:
            begin
                raddr      = lo_reg[IDX_W-1:0];
                state_next = S_NB1;
            end
            S_NB1:
            begin
                hval_next  = rdata_reg;
                raddr      = IDX_W'(lo_reg - CNT_W'(1));
                state_next = S_NB2;
            end
            S_NB2:
            begin
                lval_next  = rdata_reg;
                alu_req    = '{sub: 1'b1, a: {1'b0, hval_reg}, b: {1'b0, ival_reg}};
                dhi_next   = alu_rsp.res[VAL_W-1:0];
                state_next = S_DLO;
            end
            S_DLO:
            begin
                alu_req    = '{sub: 1'b1, a: {1'b0, ival_reg}, b: {1'b0, lval_reg}};
                dlo_next   = alu_rsp.res[VAL_W-1:0];
                state_next = S_PICK;
            end
            S_PICK:
            begin
                // An equal value gives a zero upper distance, which always wins; a tie
                // between the two neighbors goes to the lower one.
                alu_req    = '{sub: 1'b1, a: {1'b0, dhi_reg}, b: {1'b0, dlo_reg}};
                pick_hi    = have_hi && (!have_lo || !alu_rsp.ge || (dhi_reg == '0));
                pick       = pick_hi ? lo_reg : (lo_reg - CNT_W'(1));
                mval_next  = pick_hi ? hval_reg : lval_reg;
                dist_next  = pick_hi ? dhi_reg : dlo_reg;
                ptr_next   = pick + CNT_W'(1);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                alu_req    = '{sub: 1'b0, a: ALU_W'(total_reg), b: {1'b0, dist_reg}};
                acc_next   = alu_rsp.res;
                modsh_next = MOD_TOP;
                mcnt_next  = '0;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                alu_req = '{sub: 1'b1, a: acc_reg, b: modsh_reg};
                if (alu_rsp.ge)
                begin
                    acc_next = alu_rsp.res;
                end
                modsh_next = modsh_reg >> 1;
                mcnt_next  = mcnt_reg + MODC_W'(1);
                if (mcnt_reg == MODC_W'(MOD_STEPS - 1))
                begin
                    pend_next  = 1'b0;
                    state_next = S_SHDN;
                end
            end
            S_SHDN:
            begin
                // Close the gap: each entry above the removed one moves down by one.
                issue     = (ptr_reg < size_reg);
                raddr     = ptr_reg[IDX_W-1:0];
                we        = pend_reg;
                pend_next = issue;
                wa_next   = IDX_W'(ptr_reg - CNT_W'(1));
                if (issue)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (!issue && !pend_reg)
                begin
                    size_next  = size_reg - CNT_W'(1);
                    total_next = acc_reg[TOT_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next = 1'b1;
                    omatch_next = match_reg;
                    omval_next  = mval_reg;
                    odist_next  = dist_reg;
                    otot_next   = total_reg;
                    ocnt_next   = size_reg;
                    oovf_next   = ovf_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= '0;
            kind_reg   <= 1'b0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            size_reg   <= size_next;
            kind_reg   <= kind_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ikind_reg  <= ikind_next;
        ival_reg   <= ival_next;
        strict_reg <= strict_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        wa_reg     <= wa_next;
        hval_reg   <= hval_next;
        lval_reg   <= lval_next;
        dhi_reg    <= dhi_next;
        dlo_reg    <= dlo_next;
        match_reg  <= match_next;
        ovf_reg    <= ovf_next;
        mval_reg   <= mval_next;
        dist_reg   <= dist_next;
        acc_reg    <= acc_next;
        modsh_reg  <= modsh_next;
        mcnt_reg   <= mcnt_next;
        omatch_reg <= omatch_next;
        omval_reg  <= omval_next;
        odist_reg  <= odist_next;
        otot_reg   <= otot_next;
        ocnt_reg   <= ocnt_next;
        oovf_reg   <= oovf_next;
    end

    assign ocnt_ext = 32'(ocnt_reg);

    assign items.ready           = (state_reg == S_IDLE);
    assign results.valid         = ovalid_reg;
    assign results.matched       = omatch_reg;
    assign results.matched_value = omval_reg;
    assign results.distance      = odist_reg;
    assign results.running_total = otot_reg;
    assign results.pool_count    = ocnt_ext[COUNT_W-1:0];
    assign results.overflow      = oovf_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= CNT_W'(CAPACITY))
        else $error("pool size beyond capacity");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg < TOT_W'(TOTAL_MOD))
        else $error("running total not reduced");

    a_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (have_hi || have_lo))
        else $error("match with no neighbor in the pool");

    a_search_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB0) |-> (lo_reg <= size_reg && size_reg != '0))
        else $error("search position outside the pool");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !omatch_reg) |-> (omval_reg == '0 && odist_reg == '0))
        else $error("unmatched beat carries a match value");

endmodule
